FILE: rtl/core/hts_pkg.sv
package hts_pkg;

  localparam int BYTE_W                 = 8;
  localparam int NODE_W                 = 9;
  localparam int LIMIT_W                = 32;
  localparam int QUEUE_DEPTH            = 2;
  localparam int MAX_INTERNAL_NODES_DEF = 255;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

  localparam logic STATUS_SYMBOL = 1'b0;
  localparam logic STATUS_ERROR  = 1'b1;

  typedef struct packed {
    logic              frame_end;
    logic              frame_start;
    logic [BYTE_W-1:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic              run_last;
    logic              status;
    logic [BYTE_W-1:0] out_symbol;
  } res_t;

endpackage

FILE: rtl/core/hts_queue.sv
module hts_queue
  import hts_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [W-1:0]  mem [QUEUE_DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != (AW+1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/hts_back.sv
module hts_back
  import hts_pkg::*;
#(
  parameter int MAX_INTERNAL_NODES = MAX_INTERNAL_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  input  logic               item_valid,
  output logic               item_pop,
  input  in_item_t           item,
  input  logic               res_ready,
  output logic               res_valid,
  output res_t               res
);

  localparam int DW  = $clog2(MAX_INTERNAL_NODES + 1);
  localparam int SAW = (MAX_INTERNAL_NODES > 1) ? $clog2(MAX_INTERNAL_NODES) : 1;
  localparam int CAW = $clog2(2 * MAX_INTERNAL_NODES);
  localparam int CTD = 2 * MAX_INTERNAL_NODES;

  typedef enum logic [2:0] {
    S_IDLE, S_BIT, S_ATTACH, S_RELOAD, S_DEC, S_END, S_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    PH_HEADER, PH_DECODE, PH_STOP
  } phase_t;

  state_t              state, state_next;
  phase_t              phase, phase_next;
  logic [BYTE_W-1:0]   sh, sh_next;
  logic [3:0]          bits, bits_next;
  logic                fend, fend_next;
  logic [DW-1:0]       depth, depth_next;
  logic [DW-1:0]       nodes, nodes_next;
  logic [NODE_W-1:0]   top, top_next;
  logic [NODE_W-1:0]   v, v_next;
  logic [BYTE_W-1:0]   lit, lit_next;
  logic [3:0]          lit_seen, lit_seen_next;
  logic [BYTE_W-1:0]   walk, walk_next;
  logic [LIMIT_W-1:0]  emitted, emitted_next;
  logic [LIMIT_W-1:0]  out_limit, out_limit_next;
  logic                pend_valid, pend_valid_next;
  logic [BYTE_W-1:0]   pend_sym, pend_sym_next;
  logic                pend_st, pend_st_next;

  logic [NODE_W-1:0]   ct_mem [CTD];
  logic [NODE_W-1:0]   ct_q;
  logic                ct_re, ct_we;
  logic [CAW-1:0]      ct_raddr, ct_waddr;
  logic [NODE_W-1:0]   ct_wdata;

  logic [NODE_W-1:0]   stk_mem [MAX_INTERNAL_NODES];
  logic [NODE_W-1:0]   stk_q;
  logic                stk_re, stk_we;
  logic [SAW-1:0]      stk_raddr, stk_waddr;

  logic                cur;
  logic                can_post;
  logic                post;
  logic [BYTE_W-1:0]   post_sym;
  logic                post_st;
  logic                flush;
  logic                consume;
  logic [BYTE_W-1:0]   lit_shifted;

  function automatic logic [CAW-1:0] ct_addr(input logic b, input logic [BYTE_W-1:0] w);
    logic [NODE_W-1:0] we;
    we = ({1'b0, w} >= NODE_W'(MAX_INTERNAL_NODES)) ? '0 : {1'b0, w};
    return b ? CAW'(NODE_W'(MAX_INTERNAL_NODES) + we) : CAW'(we);
  endfunction

  assign cur         = sh[BYTE_W-1];
  assign can_post    = !pend_valid || res_ready;
  assign lit_shifted = {lit[BYTE_W-2:0], cur};

  always_ff @(posedge clk) begin
    if (ct_we) begin
      ct_mem[ct_waddr] <= ct_wdata;
    end
    if (ct_re) begin
      ct_q <= ct_mem[ct_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= top;
    end
    if (stk_re) begin
      stk_q <= stk_mem[stk_raddr];
    end
  end

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    sh_next         = sh;
    bits_next       = bits;
    fend_next       = fend;
    depth_next      = depth;
    nodes_next      = nodes;
    top_next        = top;
    v_next          = v;
    lit_next        = lit;
    lit_seen_next   = lit_seen;
    walk_next       = walk;
    emitted_next    = emitted;
    out_limit_next  = cfg_wr_en ? cfg_wr_data : out_limit;
    pend_valid_next = pend_valid;
    pend_sym_next   = pend_sym;
    pend_st_next    = pend_st;
    ct_re           = 1'b0;
    ct_raddr        = '0;
    ct_we           = 1'b0;
    ct_waddr        = '0;
    ct_wdata        = v;
    stk_re          = 1'b0;
    stk_raddr       = '0;
    stk_we          = 1'b0;
    stk_waddr       = '0;
    post            = 1'b0;
    post_sym        = '0;
    post_st         = STATUS_SYMBOL;
    flush           = 1'b0;
    consume         = 1'b0;
    item_pop        = 1'b0;

    case (state)
      S_IDLE: begin
        if (item_valid) begin
          item_pop   = 1'b1;
          sh_next    = item.in_byte;
          bits_next  = 4'(BYTE_W);
          fend_next  = item.frame_end;
          state_next = S_BIT;
          if (item.frame_start) begin
            phase_next    = PH_HEADER;
            depth_next    = '0;
            nodes_next    = '0;
            walk_next     = '0;
            lit_seen_next = '0;
            emitted_next  = '0;
          end
        end
      end

      S_BIT: begin
        if (bits == '0 || phase == PH_STOP) begin
          state_next = S_END;
        end else if (phase == PH_HEADER) begin
          if (lit_seen != '0) begin
            consume  = 1'b1;
            lit_next = lit_shifted;
            if (lit_seen == 4'(BYTE_W)) begin
              lit_seen_next = '0;
              v_next        = {1'b0, lit_shifted};
              state_next    = S_ATTACH;
            end else begin
              lit_seen_next = lit_seen + 1'b1;
            end
          end else if (!cur) begin
            consume       = 1'b1;
            lit_next      = '0;
            lit_seen_next = 4'd1;
          end else if (nodes >= DW'(MAX_INTERNAL_NODES)) begin
            if (can_post) begin
              post       = 1'b1;
              post_st    = STATUS_ERROR;
              phase_next = PH_STOP;
              consume    = 1'b1;
            end
          end else begin
            consume = 1'b1;
            if (depth != '0) begin
              stk_we    = 1'b1;
              stk_waddr = SAW'(depth - 1'b1);
            end
            top_next   = {1'b0, BYTE_W'(nodes)};
            depth_next = depth + 1'b1;
            nodes_next = nodes + 1'b1;
          end
        end else begin
          consume    = 1'b1;
          ct_re      = 1'b1;
          ct_raddr   = ct_addr(cur, walk);
          state_next = S_DEC;
        end
      end

      S_ATTACH: begin
        if (depth == '0) begin
          if (!v[NODE_W-1]) begin
            if (can_post) begin
              post       = 1'b1;
              post_st    = STATUS_ERROR;
              phase_next = PH_STOP;
              state_next = S_BIT;
            end
          end else begin
            phase_next = PH_DECODE;
            walk_next  = '0;
            state_next = S_BIT;
          end
        end else if (!top[NODE_W-1]) begin
          ct_we              = 1'b1;
          ct_waddr           = CAW'(top[BYTE_W-1:0]);
          top_next[NODE_W-1] = 1'b1;
          state_next         = S_BIT;
        end else begin
          ct_we      = 1'b1;
          ct_waddr   = CAW'(NODE_W'(MAX_INTERNAL_NODES) + {1'b0, top[BYTE_W-1:0]});
          depth_next = depth - 1'b1;
          v_next     = {1'b1, top[BYTE_W-1:0]};
          if (depth > DW'(1)) begin
            stk_re     = 1'b1;
            stk_raddr  = SAW'(depth - DW'(2));
            state_next = S_RELOAD;
          end
        end
      end

      S_RELOAD: begin
        top_next   = stk_q;
        state_next = S_ATTACH;
      end

      S_DEC: begin
        if (ct_q[NODE_W-1]) begin
          walk_next = ct_q[BYTE_W-1:0];
          if (bits != '0) begin
            consume  = 1'b1;
            ct_re    = 1'b1;
            ct_raddr = ct_addr(cur, ct_q[BYTE_W-1:0]);
          end else begin
            state_next = S_END;
          end
        end else if (emitted >= out_limit) begin
          phase_next = PH_STOP;
          state_next = S_END;
        end else if (can_post) begin
          post         = 1'b1;
          post_sym     = ct_q[BYTE_W-1:0];
          emitted_next = emitted + 1'b1;
          walk_next    = '0;
          if (bits != '0) begin
            consume  = 1'b1;
            ct_re    = 1'b1;
            ct_raddr = ct_addr(cur, '0);
          end else begin
            state_next = S_END;
          end
        end
      end

      S_END: begin
        if (fend && phase == PH_HEADER) begin
          if (can_post) begin
            post       = 1'b1;
            post_st    = STATUS_ERROR;
            phase_next = PH_STOP;
            state_next = S_FLUSH;
          end
        end else begin
          if (fend) begin
            phase_next = PH_STOP;
          end
          state_next = S_FLUSH;
        end
      end

      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (res_ready) begin
          flush           = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (consume) begin
      sh_next   = {sh[BYTE_W-2:0], 1'b0};
      bits_next = bits - 1'b1;
    end

    if (post) begin
      pend_valid_next = 1'b1;
      pend_sym_next   = post_sym;
      pend_st_next    = post_st;
    end

    res_valid      = (post && pend_valid) || flush;
    res.out_symbol = pend_sym;
    res.status     = pend_st;
    res.run_last   = flush;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_HEADER;
      depth      <= '0;
      nodes      <= '0;
      lit_seen   <= '0;
      walk       <= '0;
      emitted    <= '0;
      out_limit  <= LIMIT_RESET;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      depth      <= depth_next;
      nodes      <= nodes_next;
      lit_seen   <= lit_seen_next;
      walk       <= walk_next;
      emitted    <= emitted_next;
      out_limit  <= out_limit_next;
      pend_valid <= pend_valid_next;
    end
    sh       <= sh_next;
    bits     <= bits_next;
    fend     <= fend_next;
    top      <= top_next;
    v        <= v_next;
    lit      <= lit_next;
    pend_sym <= pend_sym_next;
    pend_st  <= pend_st_next;
  end

endmodule

FILE: rtl/core/huffman_tree_stream_decoder.sv
// Channel   Direction  tdata            tuser        tlast
// s_axis    in         in_byte [7:0]    frame_start  frame_end
// m_axis    out        out_symbol [7:0] status       run_last
// cfg_wr    in         out_limit [31:0] -            -
//
// A decode-phase byte runs pop, issue, one child table read per bit, end and flush.
// A header byte runs pop, one step per bit, end-of-byte check, end and flush, plus
// an attach per leaf, attach and reload per internal node closed below the root
// and an attach when the root closes. A result stall holds the bit engine.
// rst is synchronous and clears control state; memories are not cleared.
// Two-entry queues on each side let transfers stall independently of the engine.
module huffman_tree_stream_decoder
  import hts_pkg::*;
#(
  parameter int MAX_INTERNAL_NODES = MAX_INTERNAL_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [BYTE_W-1:0]  s_axis_tdata,   // in_byte
  input  logic               s_axis_tuser,   // frame_start
  input  logic               s_axis_tlast,   // frame_end
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [BYTE_W-1:0]  m_axis_tdata,   // out_symbol
  output logic               m_axis_tuser,   // status
  output logic               m_axis_tlast,   // run_last
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data
);

  in_item_t s_item;
  in_item_t q_item;
  logic     q_valid;
  logic     q_pop;
  res_t     b_res;
  logic     b_res_valid;
  logic     b_res_ready;
  res_t     m_res;

  assign s_item.in_byte     = s_axis_tdata;
  assign s_item.frame_start = s_axis_tuser;
  assign s_item.frame_end   = s_axis_tlast;

  hts_queue #(
    .W ($bits(in_item_t))
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_item),
    .out_valid (q_valid),
    .out_ready (q_pop),
    .out_data  (q_item)
  );

  hts_back #(
    .MAX_INTERNAL_NODES (MAX_INTERNAL_NODES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (q_valid),
    .item_pop    (q_pop),
    .item        (q_item),
    .res_ready   (b_res_ready),
    .res_valid   (b_res_valid),
    .res         (b_res)
  );

  hts_queue #(
    .W ($bits(res_t))
  ) u_result (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_res_valid),
    .in_ready  (b_res_ready),
    .in_data   (b_res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_res)
  );

  assign m_axis_tdata = m_res.out_symbol;
  assign m_axis_tuser = m_res.status;
  assign m_axis_tlast = m_res.run_last;

endmodule

FILE: rtl/core/hts_checker.sv
module hts_checker
  import hts_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [BYTE_W-1:0]  s_axis_tdata,
  input logic               s_axis_tuser,
  input logic               s_axis_tlast,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [BYTE_W-1:0]  m_axis_tdata,
  input logic               m_axis_tuser,
  input logic               m_axis_tlast
);

  a_reset_no_result: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready right after reset");

  a_error_form: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == STATUS_ERROR) |->
      (m_axis_tdata == '0 && m_axis_tlast))
    else $error("error result not zero or not last of its byte");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("stalled result transfer changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && !s_axis_tready) |=>
      (s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser)
       && $stable(s_axis_tlast)))
    else $error("stalled input transfer changed");

endmodule

bind huffman_tree_stream_decoder hts_checker u_hts_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: bench/tb_huffman_tree_stream_decoder.sv
`timescale 1ns / 1ps

module tb_huffman_tree_stream_decoder;
  import hts_pkg::*;

  localparam int NODES      = MAX_INTERNAL_NODES_DEF;
  localparam int STALL_MAX  = 4000;
  localparam int SETTLE     = 300;

  typedef enum logic [1:0] {SP_HEADER, SP_DECODE, SP_HALT} stream_phase_t;
  typedef enum logic [1:0] {LINK_OPEN, LINK_FAIL, LINK_ROOT_DONE} link_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [BYTE_W-1:0]   s_axis_tdata = '0;   // in_byte
  logic                s_axis_tuser = 1'b0; // frame_start
  logic                s_axis_tlast = 1'b0; // frame_end
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [BYTE_W-1:0]   m_axis_tdata;        // out_symbol
  logic                m_axis_tuser;        // status
  logic                m_axis_tlast;        // run_last
  logic                cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0]  cfg_wr_data = '0;

  huffman_tree_stream_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // decoder shadow state
  stream_phase_t       walk_phase = SP_HEADER;
  logic [8:0]          node_kids [0:2*NODES-1];
  logic [8:0]          open_nodes [0:NODES-1];
  int                  open_count = 0;
  int                  next_node = 0;
  logic [7:0]          walk = '0;
  logic [7:0]          leaf_acc = '0;
  int                  leaf_bits = 0;
  logic [31:0]         sym_count = '0;
  logic [31:0]         symbol_cap = LIMIT_RESET;

  in_item_t            byte_queue [$];
  res_t                awaited_results [$];
  bit                  bit_stream [$];
  in_item_t            next_item;
  res_t                want;

  int                  queued_total = 0;
  int                  bytes_in = 0;
  int                  symbols_seen = 0;
  int                  errors_seen = 0;
  int                  limits_written = 0;
  int                  fails = 0;
  int                  quiet_cycles = 0;
  int                  src_gap = 0;
  int                  sink_gap = 0;
  int                  src_rate = 2;
  int                  sink_rate = 2;
  bit                  calm = 1'b0;
  bit                  in_taken = 1'b0;

  function automatic void clear_stream();
    walk_phase = SP_HEADER;
    open_count = 0;
    next_node  = 0;
    walk       = '0;
    leaf_acc   = '0;
    leaf_bits  = 0;
    sym_count  = '0;
  endfunction

  function automatic link_t attach_child(logic [8:0] v);
    logic [8:0] top;
    logic [7:0] n;
    while (1'b1) begin
      if (open_count == 0) begin
        if (!v[8]) return LINK_FAIL;
        walk_phase = SP_DECODE;
        walk = '0;
        return LINK_ROOT_DONE;
      end
      top = open_nodes[open_count-1];
      n = top[7:0];
      if (!top[8]) begin
        node_kids[n] = v;
        open_nodes[open_count-1] = {1'b1, n};
        return LINK_OPEN;
      end
      node_kids[NODES + n] = v;
      open_count--;
      v = {1'b1, n};
    end
    return LINK_FAIL;
  endfunction

  function automatic link_t header_bit(logic b);
    if (leaf_bits != 0) begin
      leaf_acc = {leaf_acc[6:0], b};
      leaf_bits++;
      if (leaf_bits < 9) return LINK_OPEN;
      leaf_bits = 0;
      return attach_child({1'b0, leaf_acc});
    end
    if (!b) begin
      leaf_acc = '0;
      leaf_bits = 1;
      return LINK_OPEN;
    end
    if (next_node >= NODES || open_count >= NODES) return LINK_FAIL;
    open_nodes[open_count] = {1'b0, 8'(next_node)};
    open_count++;
    next_node++;
    return LINK_OPEN;
  endfunction

  function automatic void decode_byte(in_item_t it);
    res_t       batch [0:8];
    int         nb;
    logic       b;
    logic [8:0] v;
    nb = 0;
    if (it.frame_start) clear_stream();
    for (int i = 7; i >= 0; i--) begin
      b = it.in_byte[i];
      if (walk_phase == SP_HEADER) begin
        if (header_bit(b) == LINK_FAIL) begin
          walk_phase = SP_HALT;
          batch[nb] = {1'b0, STATUS_ERROR, 8'h00};
          nb++;
        end
      end else if (walk_phase == SP_DECODE) begin
        v = node_kids[b ? NODES + walk : walk];
        if (v[8]) begin
          walk = v[7:0];
        end else if (sym_count >= symbol_cap) begin
          walk_phase = SP_HALT;
        end else begin
          sym_count++;
          walk = '0;
          batch[nb] = {1'b0, STATUS_SYMBOL, v[7:0]};
          nb++;
        end
      end
    end
    if (it.frame_end) begin
      if (walk_phase == SP_HEADER) begin
        batch[nb] = {1'b0, STATUS_ERROR, 8'h00};
        nb++;
      end
      walk_phase = SP_HALT;
    end
    for (int k = 0; k < nb; k++) begin
      if (k == nb - 1) batch[k].run_last = 1'b1;
      awaited_results.push_back(batch[k]);
    end
  endfunction

  // stimulus builders
  function automatic void push_item(logic [7:0] d, logic st, logic en);
    byte_queue.push_back({en, st, d});
    queued_total++;
  endfunction

  function automatic void add_bits(logic [31:0] v, int n);
    for (int k = n - 1; k >= 0; k--) bit_stream.push_back(v[k]);
  endfunction

  function automatic void pack_frame(logic ends);
    bit         first_byte;
    logic [7:0] d;
    first_byte = 1'b1;
    while (bit_stream.size() > 0) begin
      for (int k = 7; k >= 0; k--)
        d[k] = (bit_stream.size() > 0) ? bit_stream.pop_front() : 1'($urandom_range(0, 1));
      push_item(d, first_byte, ends && bit_stream.size() == 0);
      first_byte = 1'b0;
    end
  endfunction

  function automatic void add_tree(int target);
    int         slots;
    int         made;
    logic [7:0] sym;
    slots = 1;
    made = 0;
    while (slots > 0) begin
      if (made == 0 || (made < target && $urandom_range(0, 1) == 1)) begin
        add_bits(1, 1);
        made++;
        slots++;
      end else begin
        if ($urandom_range(0, 3) == 0) sym = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else sym = 8'($urandom);
        add_bits(0, 1);
        add_bits(32'(sym), 8);
        slots--;
      end
    end
  endfunction

  function automatic int tree_size();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(11, 60) : $urandom_range(1, 10);
  endfunction

  function automatic void fill_random(int n_items);
    int stop_at;
    int pick;
    int cut;
    stop_at = queued_total + n_items;
    while (queued_total < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        add_tree(tree_size());
        add_bits($urandom, $urandom_range(0, 32));
        add_bits($urandom, $urandom_range(0, 32));
        pack_frame($urandom_range(0, 9) != 0);
      end else if (pick < 16) begin
        add_tree(tree_size());
        cut = $urandom_range(1, bit_stream.size() - 1);
        while (bit_stream.size() > cut) void'(bit_stream.pop_back());
        pack_frame(1'b1);
      end else if (pick == 16) begin
        add_bits(0, 1);
        add_bits($urandom, 8);
        add_bits($urandom, $urandom_range(0, 20));
        pack_frame(1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 4))
          push_item(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endfunction

  task automatic drain();
    while (bytes_in != queued_total || awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_limit(logic [31:0] v);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    symbol_cap = v;
    limits_written++;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // source side
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) src_rate = $urandom_range(0, 4);
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(1, 16) <= src_rate) begin
        src_gap = $urandom_range(0, 17);
        s_axis_tvalid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        next_item = byte_queue.pop_front();
        s_axis_tdata  <= next_item.in_byte;
        s_axis_tuser  <= next_item.frame_start;
        s_axis_tlast  <= next_item.frame_end;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // sink side
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) sink_rate = $urandom_range(0, 4);
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(1, 16) <= sink_rate) begin
      sink_gap = $urandom_range(0, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // predict on input transfer, check on output transfer
  always @(posedge clk) begin
    in_taken <= s_axis_tvalid && s_axis_tready && !rst;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte({s_axis_tlast, s_axis_tuser, s_axis_tdata});
        bytes_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          fails++;
          if (fails < 40)
            $display("%0t: unexpected result, expected none, got symbol %02h status %0d last %0d",
                     $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          want = awaited_results.pop_front();
          if (m_axis_tuser !== want.status) begin
            fails++;
            if (fails < 40)
              $display("%0t: status expected %0d, got %0d", $time, want.status, m_axis_tuser);
          end
          if (m_axis_tdata !== want.out_symbol) begin
            fails++;
            if (fails < 40)
              $display("%0t: out_symbol expected %02h, got %02h",
                       $time, want.out_symbol, m_axis_tdata);
          end
          if (m_axis_tlast !== want.run_last) begin
            fails++;
            if (fails < 40)
              $display("%0t: run_last expected %0d, got %0d", $time, want.run_last, m_axis_tlast);
          end
          if (want.status == STATUS_ERROR) errors_seen++;
          else symbols_seen++;
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_MAX) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // two-leaf tree, decode starting mid-byte, full bytes of one symbol
    add_bits(1, 1);
    add_bits(0, 1);
    add_bits(32'h00, 8);
    add_bits(0, 1);
    add_bits(32'hFF, 8);
    add_bits(32'b01011, 5);
    add_bits(32'hFF, 8);
    add_bits(32'h00, 8);
    add_bits(32'h5A, 8);
    pack_frame(1'b1);
    push_item(8'h77, 1'b0, 1'b0);
    push_item(8'h88, 1'b0, 1'b1);
    // three leaves, no end flag, cut off by the next start
    add_bits(1, 1);
    add_bits(1, 1);
    add_bits(0, 1);
    add_bits(32'h80, 8);
    add_bits(0, 1);
    add_bits(32'h01, 8);
    add_bits(0, 1);
    add_bits(32'h7F, 8);
    add_bits(32'b1001101100, 10);
    pack_frame(1'b0);
    // root as leaf
    add_bits(0, 1);
    add_bits(32'hA5, 8);
    add_bits(32'h7F, 7);
    pack_frame(1'b1);
    // header still open at end of stream
    push_item(8'hC0, 1'b1, 1'b1);
    push_item(8'hFF, 1'b0, 1'b0);
    drain();

    set_limit(32'h0000_0000);
    fill_random(40);
    drain();

    set_limit(32'h0000_0001);
    fill_random(40);
    drain();

    set_limit($urandom_range(2, 12));
    fill_random(150);
    drain();

    // one internal node too many
    set_limit(32'hFFFF_FFFF);
    repeat (8) add_bits(32'hFFFF_FFFF, 32);
    add_bits($urandom, 8);
    pack_frame(1'b1);
    fill_random(200);
    drain();

    calm = 1'b1;
    set_limit($urandom);
    fill_random(70);
    drain();

    $display("Checked %0d decoded symbols and %0d header errors from %0d input transfers",
             symbols_seen, errors_seen, bytes_in);
    $display("Ran under %0d output limit settings, zero and all ones among them", limits_written + 1);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
